FILE: src/sbst_pkg.sv
// Shared types and codes of the second-best spanning tree block.
`default_nettype none
package sbst_pkg;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_SECOND = 2'd1;
	localparam logic [1:0] ST_DISCONN   = 2'd2;
	localparam logic [1:0] ST_BAD_INPUT = 2'd3;

	// Register index of node_count (taken from paddr[2])
	localparam logic REG_NODE_COUNT = 1'b0;

	// Datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_SCAN_RD,
		OP_SCAN_CMP,
		OP_STORE,
		OP_CHECK,
		OP_SORT_RD0,
		OP_SORT_LD,
		OP_SORT_RD,
		OP_SORT_CMP,
		OP_SORT_END,
		OP_UF_INIT,
		OP_UF_RD,
		OP_UF_EDGE,
		OP_FA_RD,
		OP_FA,
		OP_FB_RD,
		OP_FB,
		OP_JOIN,
		OP_UF_DONE,
		OP_ROOT_RD,
		OP_ROOT_EDGE,
		OP_ROOT_NRD,
		OP_ROOT_WR,
		OP_PATH_RD,
		OP_PATH_EDGE,
		OP_PATH_NRD,
		OP_PATH_STEP,
		OP_FINISH,
		OP_EMIT
	} op_t;

	// Datapath status seen by the controller
	typedef struct packed {
		logic skip_new;
		logic last;
		logic idx_last;
		logic node_last;
		logic total_zero;
		logic total_lt2;
		logic cfg_bad;
		logic swapped;
		logic root_a;
		logic root_b;
		logic comps_gt1;
		logic attach;
		logic changed;
		logic in_tree;
		logic meet;
		logic out_busy;
	} stat_t;

endpackage
`default_nettype wire

FILE: src/sbst_ifs.sv
// Edge input and result output channel interfaces.
`default_nettype none
interface sbst_edge_if;
	logic       valid;
	logic       ready;
	logic [6:0] end_a;
	logic [6:0] end_b;
	logic [15:0] weight;
	logic       last_edge;
	modport source(output valid, end_a, end_b, weight, last_edge, input ready);
	modport sink(input valid, end_a, end_b, weight, last_edge, output ready);
endinterface

interface sbst_res_if;
	logic        valid;
	logic        ready;
	logic [21:0] tree_cost;
	logic [21:0] second_cost;
	logic [1:0]  status;
	modport source(output valid, tree_cost, second_cost, status, input ready);
	modport sink(input valid, tree_cost, second_cost, status, output ready);
endinterface
`default_nettype wire

FILE: src/sbst_ctrl.sv
// Controller state machine sequencing load, sort, union-find, rooting and path search.
`default_nettype none
module sbst_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sbst_pkg::stat_t st,
	output sbst_pkg::op_t   op
);
	import sbst_pkg::*;

	typedef enum logic [28:0] {
		S_IDLE      = 29'b1 << 0,
		S_SCAN_RD   = 29'b1 << 1,
		S_SCAN_CMP  = 29'b1 << 2,
		S_STORE     = 29'b1 << 3,
		S_CHECK     = 29'b1 << 4,
		S_SORT_RD0  = 29'b1 << 5,
		S_SORT_LD   = 29'b1 << 6,
		S_SORT_RD   = 29'b1 << 7,
		S_SORT_CMP  = 29'b1 << 8,
		S_SORT_END  = 29'b1 << 9,
		S_UF_INIT   = 29'b1 << 10,
		S_UF_RD     = 29'b1 << 11,
		S_UF_EDGE   = 29'b1 << 12,
		S_FA_RD     = 29'b1 << 13,
		S_FA        = 29'b1 << 14,
		S_FB_RD     = 29'b1 << 15,
		S_FB        = 29'b1 << 16,
		S_JOIN      = 29'b1 << 17,
		S_UF_DONE   = 29'b1 << 18,
		S_ROOT_RD   = 29'b1 << 19,
		S_ROOT_EDGE = 29'b1 << 20,
		S_ROOT_NRD  = 29'b1 << 21,
		S_ROOT_WR   = 29'b1 << 22,
		S_PATH_RD   = 29'b1 << 23,
		S_PATH_EDGE = 29'b1 << 24,
		S_PATH_NRD  = 29'b1 << 25,
		S_PATH_STEP = 29'b1 << 26,
		S_FINISH    = 29'b1 << 27,
		S_RESULT    = 29'b1 << 28
	} state_t;

	state_t state_q, nxt;

	// Hold the current state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	// Pick the operation and the next state
	always_comb begin
		nxt      = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op  = OP_LATCH;
					nxt = st.skip_new ? S_STORE : S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				op  = OP_SCAN_RD;
				nxt = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				op  = OP_SCAN_CMP;
				nxt = st.idx_last ? S_STORE : S_SCAN_RD;
			end
			S_STORE: begin
				op  = OP_STORE;
				nxt = st.last ? S_CHECK : S_IDLE;
			end
			S_CHECK: begin
				op = OP_CHECK;
				if (st.cfg_bad) nxt = S_RESULT;
				else if (st.total_lt2) nxt = S_UF_INIT;
				else nxt = S_SORT_RD0;
			end
			S_SORT_RD0: begin
				op  = OP_SORT_RD0;
				nxt = S_SORT_LD;
			end
			S_SORT_LD: begin
				op  = OP_SORT_LD;
				nxt = S_SORT_RD;
			end
			S_SORT_RD: begin
				op  = OP_SORT_RD;
				nxt = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				op  = OP_SORT_CMP;
				nxt = st.idx_last ? S_SORT_END : S_SORT_RD;
			end
			S_SORT_END: begin
				op  = OP_SORT_END;
				nxt = st.swapped ? S_SORT_RD0 : S_UF_INIT;
			end
			S_UF_INIT: begin
				op = OP_UF_INIT;
				if (st.node_last) nxt = st.total_zero ? S_UF_DONE : S_UF_RD;
			end
			S_UF_RD: begin
				op  = OP_UF_RD;
				nxt = S_UF_EDGE;
			end
			S_UF_EDGE: begin
				op  = OP_UF_EDGE;
				nxt = S_FA_RD;
			end
			S_FA_RD: begin
				op  = OP_FA_RD;
				nxt = S_FA;
			end
			S_FA: begin
				op  = OP_FA;
				nxt = st.root_a ? S_FB_RD : S_FA_RD;
			end
			S_FB_RD: begin
				op  = OP_FB_RD;
				nxt = S_FB;
			end
			S_FB: begin
				op  = OP_FB;
				nxt = st.root_b ? S_JOIN : S_FB_RD;
			end
			S_JOIN: begin
				op  = OP_JOIN;
				nxt = st.idx_last ? S_UF_DONE : S_UF_RD;
			end
			S_UF_DONE: begin
				op = OP_UF_DONE;
				if (st.comps_gt1) nxt = S_RESULT;
				else if (st.total_zero) nxt = S_FINISH;
				else nxt = S_ROOT_RD;
			end
			S_ROOT_RD: begin
				op  = OP_ROOT_RD;
				nxt = S_ROOT_EDGE;
			end
			S_ROOT_EDGE: begin
				op = OP_ROOT_EDGE;
				if (st.attach) nxt = S_ROOT_NRD;
				else if (st.idx_last && !st.changed) nxt = S_PATH_RD;
				else nxt = S_ROOT_RD;
			end
			S_ROOT_NRD: begin
				op  = OP_ROOT_NRD;
				nxt = S_ROOT_WR;
			end
			S_ROOT_WR: begin
				op  = OP_ROOT_WR;
				nxt = S_ROOT_RD;
			end
			S_PATH_RD: begin
				op  = OP_PATH_RD;
				nxt = S_PATH_EDGE;
			end
			S_PATH_EDGE: begin
				op = OP_PATH_EDGE;
				if (!st.in_tree) nxt = S_PATH_NRD;
				else nxt = st.idx_last ? S_FINISH : S_PATH_RD;
			end
			S_PATH_NRD: begin
				op  = OP_PATH_NRD;
				nxt = S_PATH_STEP;
			end
			S_PATH_STEP: begin
				op = OP_PATH_STEP;
				if (!st.meet) nxt = S_PATH_NRD;
				else nxt = st.idx_last ? S_FINISH : S_PATH_RD;
			end
			S_FINISH: begin
				op  = OP_FINISH;
				nxt = S_RESULT;
			end
			S_RESULT: begin
				if (!st.out_busy) begin
					op  = OP_EMIT;
					nxt = S_IDLE;
				end
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: src/sbst_dp.sv
// Datapath: edge, tree-mark, set and node memories, counters and result registers.
`default_nettype none
module sbst_dp #(
	parameter int MAX_NODES   = 64,
	parameter int MAX_EDGES   = 256,
	parameter int WEIGHT_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sbst_pkg::op_t   op,
	output sbst_pkg::stat_t st,
	input  logic [6:0]      node_count,
	input  logic [6:0]      end_a,
	input  logic [6:0]      end_b,
	input  logic [15:0]     weight,
	input  logic            last_edge,
	input  logic            res_ready,
	output logic            res_valid,
	output logic [21:0]     tree_cost,
	output logic [21:0]     second_cost,
	output logic [1:0]      status
);
	import sbst_pkg::*;

	localparam int NB = $clog2(MAX_NODES);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int TW = $clog2(MAX_EDGES + 1);
	localparam int W  = WEIGHT_BITS;
	localparam int KW = W + 2 * NB;
	localparam int NW = 2 * NB + W;
	localparam int SW = W + NB;
	localparam int CW = SW + 1;

	// Memories
	logic [KW-1:0] edge_mem [MAX_EDGES];
	logic          tree_mem [MAX_EDGES];
	logic [NB-1:0] sp_mem   [MAX_NODES];
	logic [NW-1:0] node_mem [MAX_NODES];

	logic [KW-1:0] edge_rd_q;
	logic          tree_rd_q;
	logic [NB-1:0] sp_rd_q;
	logic [NW-1:0] na_q, nb_q;

	// Control and working registers
	logic [TW-1:0] total_q;
	logic          err_q;
	logic [NB-1:0] maxhi_q;
	logic          res_valid_q;
	logic [EW-1:0] idx_q;
	logic [NB-1:0] nidx_q;
	logic [KW-1:0] key_q, carry_q;
	logic          bad_q, self_q, last_q, dup_q, swapped_q, changed_q, any_q;
	logic [MAX_NODES-1:0] have_q;
	logic [NB-1:0] ra_q, rb_q, pa_q, cb_q, u_q, v_q;
	logic [W-1:0]  w_q, mx_q;
	logic [NB:0]   comps_q;
	logic [SW-1:0] sum_q;
	logic [CW-1:0] best_q;
	logic [21:0]   r_tree_q, r_second_q, o_tree_q, o_second_q;
	logic [1:0]    r_status_q, o_status_q;

	// Incoming edge decode
	logic [6:0]    lo7, hi7;
	logic          new_bad;
	logic [KW-1:0] new_key;

	assign lo7     = (end_a < end_b) ? end_a : end_b;
	assign hi7     = (end_a < end_b) ? end_b : end_a;
	assign new_bad = (end_a == 7'd0) || (end_b == 7'd0) ||
	                 (32'(end_a) > MAX_NODES) || (32'(end_b) > MAX_NODES);
	assign new_key = {W'(weight), NB'(lo7 - 7'd1), NB'(hi7 - 7'd1)};

	// Fields of the edge read back
	logic [W-1:0]  rd_w;
	logic [NB-1:0] rd_lo, rd_hi;
	assign rd_w  = edge_rd_q[KW-1:2*NB];
	assign rd_lo = edge_rd_q[2*NB-1:NB];
	assign rd_hi = edge_rd_q[NB-1:0];

	// Fields of the two node reads
	logic [NB-1:0] par_a, par_b, lvl_a, lvl_b;
	logic [W-1:0]  plw_a, plw_b, m1, m2;
	assign par_a = na_q[NW-1:NB+W];
	assign plw_a = na_q[NB+W-1:NB];
	assign lvl_a = na_q[NB-1:0];
	assign par_b = nb_q[NW-1:NB+W];
	assign plw_b = nb_q[NB+W-1:NB];
	assign lvl_b = nb_q[NB-1:0];
	assign m1    = (plw_a > mx_q) ? plw_a : mx_q;
	assign m2    = (plw_b > m1) ? plw_b : m1;

	logic          idx_last, total_full, store_ok, attach, meet;
	logic [CW-1:0] cand;
	assign idx_last   = (TW'(idx_q) == total_q - TW'(1));
	assign total_full = (total_q == TW'(MAX_EDGES));
	assign store_ok   = !bad_q && !self_q && !dup_q && !total_full;
	assign attach     = tree_rd_q && (have_q[rd_lo] != have_q[rd_hi]);
	assign meet       = (lvl_a == lvl_b) && (u_q == v_q);
	assign cand       = CW'(sum_q) - CW'(mx_q) + CW'(w_q);

	// Status back to the controller
	always_comb begin
		st.skip_new   = new_bad || (end_a == end_b) || (total_q == '0);
		st.last       = last_q;
		st.idx_last   = idx_last;
		st.node_last  = (nidx_q == NB'(node_count - 7'd1));
		st.total_zero = (total_q == '0);
		st.total_lt2  = (total_q < TW'(2));
		st.cfg_bad    = err_q || (node_count == 7'd0) || (32'(node_count) > MAX_NODES) ||
		                (32'(maxhi_q) >= 32'(node_count));
		st.swapped    = swapped_q;
		st.root_a     = (sp_rd_q == ra_q);
		st.root_b     = (sp_rd_q == rb_q);
		st.comps_gt1  = (comps_q > (NB+1)'(1));
		st.attach     = attach;
		st.changed    = changed_q;
		st.in_tree    = tree_rd_q;
		st.meet       = meet;
		st.out_busy   = res_valid_q;
	end

	// Memory port selection
	logic          edge_we, tree_we, sp_we, node_we;
	logic [EW-1:0] edge_wa, edge_ra;
	logic [KW-1:0] edge_wd;
	logic [NB-1:0] sp_wa, sp_wd, sp_ra, node_wa, node_ra;
	logic [NW-1:0] node_wd;

	always_comb begin
		edge_we = 1'b0;
		edge_wa = total_q[EW-1:0];
		edge_wd = key_q;
		sp_we   = 1'b0;
		sp_wa   = nidx_q;
		sp_wd   = nidx_q;
		node_we = 1'b0;
		node_wa = cb_q;
		node_wd = {pa_q, w_q, lvl_a + NB'(1)};
		tree_we = (op == OP_JOIN);
		edge_ra = (op == OP_SORT_RD0) ? '0 : idx_q;
		sp_ra   = (op == OP_FB_RD) ? rb_q : ra_q;
		node_ra = (op == OP_ROOT_NRD) ? pa_q : u_q;
		case (op)
			OP_STORE: edge_we = store_ok;
			OP_SORT_CMP: begin
				edge_we = 1'b1;
				edge_wa = idx_q - EW'(1);
				edge_wd = (carry_q > edge_rd_q) ? edge_rd_q : carry_q;
			end
			OP_SORT_END: begin
				edge_we = 1'b1;
				edge_wa = EW'(total_q - TW'(1));
				edge_wd = carry_q;
			end
			OP_UF_INIT: sp_we = 1'b1;
			OP_JOIN: begin
				sp_we = (ra_q != rb_q);
				sp_wa = ra_q;
				sp_wd = rb_q;
			end
			OP_UF_DONE: begin
				node_we = 1'b1;
				node_wa = '0;
				node_wd = '0;
			end
			OP_ROOT_WR: node_we = 1'b1;
			default: ;
		endcase
	end

	// Memory access, read data registered
	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[edge_wa] <= edge_wd;
		if (tree_we) tree_mem[idx_q] <= (ra_q != rb_q);
		if (sp_we) sp_mem[sp_wa] <= sp_wd;
		if (node_we) node_mem[node_wa] <= node_wd;
		edge_rd_q <= edge_mem[edge_ra];
		tree_rd_q <= tree_mem[idx_q];
		sp_rd_q   <= sp_mem[sp_ra];
		na_q      <= node_mem[node_ra];
		nb_q      <= node_mem[v_q];
	end

	// Graph bookkeeping and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			err_q       <= 1'b0;
			maxhi_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			if (op == OP_STORE) begin
				if (bad_q || (!self_q && !dup_q && total_full)) err_q <= 1'b1;
				if (store_ok) begin
					total_q <= total_q + TW'(1);
					if (key_q[NB-1:0] > maxhi_q) maxhi_q <= key_q[NB-1:0];
				end
			end
			if (op == OP_EMIT) begin
				res_valid_q <= 1'b1;
				total_q     <= '0;
				err_q       <= 1'b0;
				maxhi_q     <= '0;
			end
		end
	end

	// Working registers of each phase
	always_ff @(posedge clk) begin
		case (op)
			OP_LATCH: begin
				key_q  <= new_key;
				bad_q  <= new_bad;
				self_q <= (end_a == end_b);
				last_q <= last_edge;
				dup_q  <= 1'b0;
				idx_q  <= '0;
			end
			OP_SCAN_CMP: begin
				if (edge_rd_q == key_q) dup_q <= 1'b1;
				idx_q <= idx_q + EW'(1);
			end
			OP_CHECK: begin
				r_tree_q   <= '0;
				r_second_q <= '0;
				r_status_q <= ST_BAD_INPUT;
				comps_q    <= (NB+1)'(node_count);
				sum_q      <= '0;
				nidx_q     <= '0;
				idx_q      <= '0;
			end
			OP_SORT_RD0: begin
				idx_q     <= EW'(1);
				swapped_q <= 1'b0;
			end
			OP_SORT_LD: carry_q <= edge_rd_q;
			OP_SORT_CMP: begin
				if (carry_q > edge_rd_q) swapped_q <= 1'b1;
				else carry_q <= edge_rd_q;
				idx_q <= idx_q + EW'(1);
			end
			OP_UF_INIT: begin
				nidx_q <= nidx_q + NB'(1);
				idx_q  <= '0;
			end
			OP_UF_EDGE: begin
				ra_q <= rd_lo;
				rb_q <= rd_hi;
				w_q  <= rd_w;
			end
			OP_FA: ra_q <= sp_rd_q;
			OP_FB: rb_q <= sp_rd_q;
			OP_JOIN: begin
				if (ra_q != rb_q) begin
					comps_q <= comps_q - (NB+1)'(1);
					sum_q   <= sum_q + SW'(w_q);
				end
				idx_q <= idx_q + EW'(1);
			end
			OP_UF_DONE: begin
				r_tree_q   <= '0;
				r_second_q <= '0;
				r_status_q <= ST_DISCONN;
				have_q     <= MAX_NODES'(1);
				idx_q      <= '0;
				changed_q  <= 1'b0;
				any_q      <= 1'b0;
				best_q     <= '0;
			end
			OP_ROOT_EDGE: begin
				pa_q <= have_q[rd_lo] ? rd_lo : rd_hi;
				cb_q <= have_q[rd_lo] ? rd_hi : rd_lo;
				w_q  <= rd_w;
				if (!attach) begin
					if (idx_last) begin
						idx_q     <= '0;
						changed_q <= 1'b0;
					end else begin
						idx_q <= idx_q + EW'(1);
					end
				end
			end
			OP_ROOT_WR: begin
				have_q[cb_q] <= 1'b1;
				if (idx_last) begin
					idx_q     <= '0;
					changed_q <= 1'b0;
				end else begin
					idx_q     <= idx_q + EW'(1);
					changed_q <= 1'b1;
				end
			end
			OP_PATH_EDGE: begin
				if (tree_rd_q) begin
					idx_q <= idx_q + EW'(1);
				end else begin
					u_q  <= rd_lo;
					v_q  <= rd_hi;
					w_q  <= rd_w;
					mx_q <= '0;
				end
			end
			OP_PATH_STEP: begin
				if (lvl_a > lvl_b) begin
					mx_q <= m1;
					u_q  <= par_a;
				end else if (lvl_b > lvl_a) begin
					mx_q <= (plw_b > mx_q) ? plw_b : mx_q;
					v_q  <= par_b;
				end else if (u_q != v_q) begin
					mx_q <= m2;
					u_q  <= par_a;
					v_q  <= par_b;
				end else begin
					if (!any_q || cand < best_q) begin
						best_q <= cand;
						any_q  <= 1'b1;
					end
					idx_q <= idx_q + EW'(1);
				end
			end
			OP_FINISH: begin
				r_tree_q   <= 22'(sum_q);
				r_second_q <= any_q ? 22'(best_q) : 22'd0;
				r_status_q <= any_q ? ST_OK : ST_NO_SECOND;
			end
			OP_EMIT: begin
				o_tree_q   <= r_tree_q;
				o_second_q <= r_second_q;
				o_status_q <= r_status_q;
			end
			default: ;
		endcase
	end

	assign res_valid   = res_valid_q;
	assign tree_cost   = o_tree_q;
	assign second_cost = o_second_q;
	assign status      = o_status_q;

endmodule
`default_nettype wire

FILE: src/second_best_spanning_tree.sv
// Top level of the second-best minimum spanning tree block.
//
// Edges enter one transaction at a time and are stored in an edge memory with
// one write and one read port; each edge is checked against all stored edges
// for an exact duplicate. The transaction with last_edge set then runs the
// computation on one shared datapath: bubble-sort passes over the edge memory
// (up to one pass per stored edge), a set-table initialization over node_count
// entries, union-find over the sorted edges, rooting of the tree at node 1 in
// passes over the edges until nothing attaches, and a level-by-level climb for
// every non-tree edge. One result transaction follows; the next edge can be
// taken while it waits. node_count is written through the APB port at address
// 0; the user must write it only while idle, as the block does not enforce it.
`default_nettype none
module second_best_spanning_tree #(
	parameter int MAX_NODES   = 64,
	parameter int MAX_EDGES   = 256,
	parameter int WEIGHT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	sbst_edge_if.sink   edge_in,
	sbst_res_if.source  res_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sbst_pkg::*;

	op_t        op;
	stat_t      st;
	logic [6:0] node_count_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 7'd1;
		end else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT) begin
			node_count_q <= pwdata[6:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count_q) : 32'd0;

	sbst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (edge_in.valid),
		.in_ready (edge_in.ready),
		.st       (st),
		.op       (op)
	);

	sbst_dp #(
		.MAX_NODES   (MAX_NODES),
		.MAX_EDGES   (MAX_EDGES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.st          (st),
		.node_count  (node_count_q),
		.end_a       (edge_in.end_a),
		.end_b       (edge_in.end_b),
		.weight      (edge_in.weight),
		.last_edge   (edge_in.last_edge),
		.res_ready   (res_out.ready),
		.res_valid   (res_out.valid),
		.tree_cost   (res_out.tree_cost),
		.second_cost (res_out.second_cost),
		.status      (res_out.status)
	);

	// A transaction without last_edge never raises a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(edge_in.valid && edge_in.ready && !edge_in.last_edge && !res_out.valid)
		|=> !res_out.valid)
		else $error("result raised by a non-final edge");

	// Error and disconnected results carry zero costs
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && (res_out.status == ST_BAD_INPUT || res_out.status == ST_DISCONN))
		|-> (res_out.tree_cost == 22'd0 && res_out.second_cost == 22'd0))
		else $error("nonzero cost on an error result");

	// No second tree means no second cost
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && res_out.status == ST_NO_SECOND) |-> res_out.second_cost == 22'd0)
		else $error("second cost without a second tree");

	// Input is never taken while the controller works on the graph
	assert property (@(posedge clk) disable iff (!arst_n)
		(op != OP_NONE && op != OP_LATCH && op != OP_EMIT) |-> !edge_in.ready)
		else $error("edge ready during computation");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench of the second-best spanning tree block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import sbst_pkg::*;

	typedef struct packed {
		logic [21:0] tree_cost;
		logic [21:0] second_cost;
		logic [1:0]  status;
	} mst_result_t;

	// Tracks the edge list, works out the expected result of each graph and checks it
	class spanning_checker;
		int unsigned node_cfg = 1;
		bit [31:0]   edge_keys[$];
		bit          input_bad;
		mst_result_t expected_results[$];
		int          errors;
		int          graphs_checked;

		int          link[64];

		function void set_nodes(bit [6:0] v);
			node_cfg = v;
		endfunction

		// Union-find root lookup with path halving
		function int set_root(int x);
			while (link[x] != x) begin
				link[x] = link[link[x]];
				x = link[x];
			end
			return x;
		endfunction

		function mst_result_t compute_expected();
			mst_result_t r;
			int n, comps, ra, rb, u, v, t, i, j;
			int up[64];
			int depth[64];
			bit have[64];
			bit in_tree[$];
			longint up_w[64];
			longint total, best, mx, cand;
			bit any;
			n = node_cfg;
			total = 0;
			best = 0;
			any = 0;
			r = '0;
			if (input_bad || n == 0 || n > 64) begin
				r.status = ST_BAD_INPUT;
				return r;
			end
			foreach (edge_keys[k])
				if (edge_keys[k][7:0] >= n) begin
					r.status = ST_BAD_INPUT;
					return r;
				end
			edge_keys.sort();
			// Kruskal over the sorted list
			for (i = 0; i < n; i++) link[i] = i;
			comps = n;
			foreach (edge_keys[k]) begin
				ra = set_root(edge_keys[k][15:8]);
				rb = set_root(edge_keys[k][7:0]);
				in_tree = {in_tree, bit'(ra != rb)};
				if (ra != rb) begin
					link[ra] = rb;
					comps--;
					total += edge_keys[k][31:16];
				end
			end
			if (comps > 1) begin
				r.status = ST_DISCONN;
				return r;
			end
			// Root the tree at node 1
			for (i = 0; i < n; i++) begin
				up[i] = i;
				depth[i] = 0;
				up_w[i] = 0;
				have[i] = (i == 0);
			end
			for (j = 0; j < n; j++)
				foreach (edge_keys[k]) begin
					u = edge_keys[k][15:8];
					v = edge_keys[k][7:0];
					if (!in_tree[k] || have[u] == have[v]) continue;
					if (have[v]) begin
						t = u;
						u = v;
						v = t;
					end
					up[v] = u;
					up_w[v] = edge_keys[k][31:16];
					depth[v] = depth[u] + 1;
					have[v] = 1;
				end
			// Heaviest tree edge on each non-tree edge's cycle
			foreach (edge_keys[k]) begin
				if (in_tree[k]) continue;
				u = edge_keys[k][15:8];
				v = edge_keys[k][7:0];
				mx = 0;
				while (depth[u] > depth[v]) begin
					if (up_w[u] > mx) mx = up_w[u];
					u = up[u];
				end
				while (depth[v] > depth[u]) begin
					if (up_w[v] > mx) mx = up_w[v];
					v = up[v];
				end
				while (u != v) begin
					if (up_w[u] > mx) mx = up_w[u];
					if (up_w[v] > mx) mx = up_w[v];
					u = up[u];
					v = up[v];
				end
				cand = total - mx + edge_keys[k][31:16];
				if (!any || cand < best) begin
					best = cand;
					any = 1;
				end
			end
			r.tree_cost = total[21:0];
			r.second_cost = any ? best[21:0] : 22'd0;
			r.status = any ? ST_OK : ST_NO_SECOND;
			return r;
		endfunction

		function void note_edge(bit [6:0] a, bit [6:0] b, bit [15:0] w, bit last);
			bit [6:0]  lo, hi;
			bit [31:0] k;
			bit        dup;
			if (a == 0 || b == 0 || a > 64 || b > 64) begin
				input_bad = 1;
			end else if (a != b) begin
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
				k = {w, 8'(lo - 1), 8'(hi - 1)};
				dup = 0;
				foreach (edge_keys[i]) if (edge_keys[i] == k) dup = 1;
				if (!dup) begin
					if (edge_keys.size() >= 256) input_bad = 1;
					else edge_keys = {edge_keys, k};
				end
			end
			if (last) begin
				expected_results = {expected_results, compute_expected()};
				edge_keys.delete();
				input_bad = 0;
			end
		endfunction

		function void check_result(mst_result_t got);
			mst_result_t exp_r;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result tree=%0d second=%0d status=%0d", $time,
					got.tree_cost, got.second_cost, got.status);
				errors++;
				return;
			end
			exp_r = expected_results.pop_front();
			graphs_checked++;
			if (got.tree_cost !== exp_r.tree_cost) begin
				$display("%0t: tree_cost expected %0d actual %0d", $time,
					exp_r.tree_cost, got.tree_cost);
				errors++;
			end
			if (got.second_cost !== exp_r.second_cost) begin
				$display("%0t: second_cost expected %0d actual %0d", $time,
					exp_r.second_cost, got.second_cost);
				errors++;
			end
			if (got.status !== exp_r.status) begin
				$display("%0t: status expected %0d actual %0d", $time,
					exp_r.status, got.status);
				errors++;
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 600;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sbst_edge_if edge_ch();
	sbst_res_if  res_ch();

	spanning_checker sb = new();
	int          send_idle_pct;
	int          recv_stall_pct;
	int          stall_cycles;
	int          edges_sent;

	second_best_spanning_tree u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.edge_in(edge_ch),
		.res_out(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Random backpressure on the result channel
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Observe transactions on both channels and run the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (edge_ch.valid && edge_ch.ready)
				sb.note_edge(edge_ch.end_a, edge_ch.end_b, edge_ch.weight, edge_ch.last_edge);
			if (res_ch.valid && res_ch.ready)
				sb.check_result({res_ch.tree_cost, res_ch.second_cost, res_ch.status});
			if ((edge_ch.valid && edge_ch.ready) || (res_ch.valid && res_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("second_best_spanning_tree regression: fail");
				$finish;
			end
		end
	end

	task automatic apb_write(bit [2:0] addr, bit [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr[2] == REG_NODE_COUNT) sb.set_nodes(data[6:0]);
	endtask

	// Hold one edge until the block takes it; idle first at random
	task automatic send_edge(bit [6:0] a, bit [6:0] b, bit [15:0] w, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			edge_ch.valid <= 1'b0;
			@(posedge clk);
		end
		edge_ch.valid <= 1'b1;
		edge_ch.end_a <= a;
		edge_ch.end_b <= b;
		edge_ch.weight <= w;
		edge_ch.last_edge <= last;
		do @(posedge clk); while (!edge_ch.ready);
		edges_sent++;
	endtask

	// Drop valid, drain all results, then let the block finish any loading
	task automatic settle();
		edge_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_graph();
		int n, extra, i, j, t;
		bit [15:0] wmax;
		bit [6:0] qa[$], qb[$];
		bit [15:0] qw[$];
		n = ($urandom_range(9) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 9);
		wmax = $urandom_range(1) ? 16'd15 : 16'hFFFF;
		settle();
		apb_write(3'd0, ($urandom_range(19) == 0) ? n - 1 : n);
		// Spanning edges, with one left out now and then
		for (i = 2; i <= n; i++) begin
			if ($urandom_range(24) == 0) continue;
			j = $urandom_range(1, i - 1);
			if ($urandom_range(1)) begin
				qa = {qa, 7'(i)};
				qb = {qb, 7'(j)};
			end else begin
				qa = {qa, 7'(j)};
				qb = {qb, 7'(i)};
			end
			qw = {qw, 16'($urandom_range(wmax))};
		end
		extra = $urandom_range(0, 6);
		for (i = 0; i < extra; i++) begin
			if (qa.size() != 0 && $urandom_range(5) == 0) begin
				j = $urandom_range(qa.size() - 1);
				qa = {qa, qb[j]};
				qb = {qb, qa[j]};
				qw = {qw, qw[j]};
			end else begin
				qa = {qa, 7'($urandom_range(1, n))};
				qb = {qb, 7'($urandom_range(1, n))};
				qw = {qw, 16'($urandom_range(wmax))};
			end
		end
		if ($urandom_range(29) == 0) begin
			qa = {qa, 7'($urandom_range(127))};
			qb = {qb, 7'($urandom_range(127))};
			qw = {qw, 16'($urandom_range(16'hFFFF))};
		end
		if (qa.size() == 0) begin
			qa = {qa, 7'd1};
			qb = {qb, 7'd1};
			qw = {qw, 16'd0};
		end
		// Shuffle the arrival order
		for (i = qa.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = qa[i]; qa[i] = qa[j]; qa[j] = 7'(t);
			t = qb[i]; qb[i] = qb[j]; qb[j] = 7'(t);
			t = qw[i]; qw[i] = qw[j]; qw[j] = 16'(t);
		end
		foreach (qa[k]) send_edge(qa[k], qb[k], qw[k], k == qa.size() - 1);
	endtask

	initial begin
		int phase, quota;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		edge_ch.valid = 1'b0;
		edge_ch.end_a = '0;
		edge_ch.end_b = '0;
		edge_ch.weight = '0;
		edge_ch.last_edge = 1'b0;
		res_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		stall_cycles = 0;
		edges_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: lone self-loop at reset node count
		send_edge(7'd1, 7'd1, 16'd0, 1'b1);
		settle();
		apb_write(3'd4, 32'hFFFF_FFFF);
		apb_write(3'd0, 32'd3);
		// Triangle with extreme weights
		send_edge(7'd1, 7'd2, 16'd0, 1'b0);
		send_edge(7'd2, 7'd3, 16'hFFFF, 1'b0);
		send_edge(7'd3, 7'd1, 16'hFFFF, 1'b1);
		// Duplicate collapsed, tree with no spare edge
		send_edge(7'd1, 7'd2, 16'd5, 1'b0);
		send_edge(7'd2, 7'd1, 16'd5, 1'b0);
		send_edge(7'd2, 7'd3, 16'd7, 1'b1);
		// Disconnected graph
		send_edge(7'd1, 7'd2, 16'd9, 1'b1);
		// Endpoint zero and all-ones endpoint
		send_edge(7'd0, 7'd1, 16'd1, 1'b1);
		send_edge(7'd127, 7'd2, 16'd1, 1'b1);
		settle();
		apb_write(3'd0, 32'd64);
		// Endpoint just past the node range, then the top node
		send_edge(7'd65, 7'd1, 16'd3, 1'b1);
		send_edge(7'd64, 7'd1, 16'hAAAA, 1'b0);
		send_edge(7'd1, 7'd64, 16'h5555, 1'b1);
		settle();
		apb_write(3'd0, 32'd2);
		// Stored endpoint above node count
		send_edge(7'd1, 7'd3, 16'd4, 1'b1);
		settle();
		apb_write(3'd0, 32'd0);
		send_edge(7'd1, 7'd1, 16'd4, 1'b1);
		settle();
		apb_write(3'd0, 32'd127);
		send_edge(7'd1, 7'd2, 16'd4, 1'b1);
		settle();
		apb_write(3'd0, 32'd1);
		send_edge(7'd1, 7'd1, 16'hFFFF, 1'b1);

		// Random graphs under each idling pattern
		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 86 : (phase == 3) ? 34 : 0;
			recv_stall_pct = (phase == 2) ? 86 : (phase == 3) ? 34 : 0;
			quota = edges_sent + 35;
			while (edges_sent < quota) send_random_graph();
		end

		// Full edge store in the worst sort order
		send_idle_pct = 0;
		recv_stall_pct = 0;
		settle();
		apb_write(3'd0, 32'd64);
		for (int k = 0; k < 256; k++)
			send_edge(7'(1 + k % 32), 7'(33 + (k / 32) % 32), 16'(1000 - k), k == 255);
		settle();

		$display("Covered %0d edges over %0d graphs: directed corners, random graphs",
			edges_sent, sb.graphs_checked);
		$display("under four idle/stall mixes, and a full edge store in reverse order.");
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("second_best_spanning_tree regression: pass");
		else
			$display("second_best_spanning_tree regression: fail");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
src/sbst_pkg.sv
src/sbst_ifs.sv
src/sbst_ctrl.sv
src/sbst_dp.sv
src/second_best_spanning_tree.sv
bench/tb_top.sv
